>>> rtl/core/bitmap_text_renderer_top_macros.svh
// ----------------------------------------------------------------------------
// Bitmap text renderer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_TEXT_RENDERER_TOP_MACROS_SVH
`define BITMAP_TEXT_RENDERER_TOP_MACROS_SVH

// same-cycle implication
`define BTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/btr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap text renderer package
// Shared constants, the glyph job record and the 8x16 glyph ROM.
// ----------------------------------------------------------------------------
package btr_pkg;

    localparam int MAX_COORD   = 4096;
    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_COLS  = 8;

    localparam logic [12:0] COORD_LIM = 13'(MAX_COORD);
    localparam logic [12:0] CUR_MAX   = 13'(2 * MAX_COORD - 1);

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [6:0] SUBST_CODE   = 7'h3F;

    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ROW_PITCH     = 2'd2;

    localparam logic [6:0] CODE_BANG = 7'd33;
    localparam logic [6:0] CODE_A    = 7'd65;
    localparam logic [6:0] CODE_B    = 7'd66;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [3:0]  rows_m1;
        logic [3:0]  cnt;
        logic [6:0]  idx;
        logic [31:0] fg;
        logic [31:0] bg;
    } job_t;

    function automatic logic [7:0] glyph_row(input logic [6:0] idx, input logic [3:0] row);
        logic [7:0] bits;
        bits = 8'h00;
        unique case (idx)
            CODE_BANG:
            begin
                unique case (row)
                    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9: bits = 8'h18;
                    default: bits = 8'h00;
                endcase
            end
            CODE_A:
            begin
                unique case (row)
                    4'd2: bits = 8'h18;
                    4'd3: bits = 8'h3C;
                    4'd4, 4'd5, 4'd7, 4'd8, 4'd9: bits = 8'h66;
                    4'd6: bits = 8'h7E;
                    default: bits = 8'h00;
                endcase
            end
            CODE_B:
            begin
                unique case (row)
                    4'd2, 4'd5, 4'd9: bits = 8'h7C;
                    4'd3, 4'd4, 4'd6, 4'd7, 4'd8: bits = 8'h66;
                    default: bits = 8'h00;
                endcase
            end
            default: bits = 8'h00;
        endcase
        return bits;
    endfunction

endpackage

>>> rtl/core/btr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap text renderer front end
// Accepts characters, tracks the cursor and builds clipped glyph jobs.
// ----------------------------------------------------------------------------
module btr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // origin_x, origin_y, char_code, fore, back
    input  logic                 s_tuser,   // start_req
    input  logic [12:0]          screen_width,
    input  logic [12:0]          screen_height,
    input  logic                 q_full,
    output logic                 q_push,
    output btr_pkg::job_t        q_job
);

    logic [11:0] line_start_reg, line_start_next;
    logic [12:0] cursor_x_reg, cursor_x_next;
    logic [12:0] cursor_y_reg, cursor_y_next;

    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [7:0]  char_code;
    logic        accept;
    logic [11:0] ls;
    logic [12:0] cx0, cy0, cx1, cy1;
    logic [12:0] wlim, hlim, xspan, yspan;
    logic        is_nl, draw, wrap;

    function automatic logic [12:0] sat_add(input logic [12:0] a, input logic [4:0] inc);
        logic [13:0] sum;
        sum = {1'b0, a} + 14'(inc);
        return (sum > {1'b0, btr_pkg::CUR_MAX}) ? btr_pkg::CUR_MAX : sum[12:0];
    endfunction

    assign origin_x  = s_tdata[11:0];
    assign origin_y  = s_tdata[23:12];
    assign char_code = s_tdata[31:24];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ls    = s_tuser ? origin_x : line_start_reg;
        cx0   = s_tuser ? {1'b0, origin_x} : cursor_x_reg;
        cy0   = s_tuser ? {1'b0, origin_y} : cursor_y_reg;
        wlim  = (screen_width > btr_pkg::COORD_LIM) ? btr_pkg::COORD_LIM : screen_width;
        hlim  = (screen_height > btr_pkg::COORD_LIM) ? btr_pkg::COORD_LIM : screen_height;
        is_nl = (char_code == btr_pkg::NEWLINE_CODE);
        xspan = wlim - cx0;
        yspan = hlim - cy0;
        draw  = !is_nl && (cx0 < wlim) && (cy0 < hlim);

        q_job.x       = cx0[11:0];
        q_job.y       = cy0[11:0];
        q_job.rows_m1 = (yspan >= 13'(btr_pkg::GLYPH_ROWS)) ? 4'd15 : 4'(yspan - 13'd1);
        q_job.cnt     = (xspan >= 13'(btr_pkg::GLYPH_COLS)) ? 4'd8 : xspan[3:0];
        q_job.idx     = char_code[7] ? btr_pkg::SUBST_CODE : char_code[6:0];
        q_job.fg      = s_tdata[63:32];
        q_job.bg      = s_tdata[95:64];

        cx1  = is_nl ? {1'b0, ls} : sat_add(cx0, 5'(btr_pkg::GLYPH_COLS));
        cy1  = is_nl ? sat_add(cy0, 5'(btr_pkg::GLYPH_ROWS)) : cy0;
        wrap = ({1'b0, cx1} + 14'(btr_pkg::GLYPH_COLS)) > {1'b0, screen_width};

        line_start_next = ls;
        cursor_x_next   = wrap ? {1'b0, ls} : cx1;
        cursor_y_next   = wrap ? sat_add(cy1, 5'(btr_pkg::GLYPH_ROWS)) : cy1;
    end

    assign q_push = accept && draw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
        end
        else if (accept)
        begin
            line_start_reg <= line_start_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
        end
    end

endmodule

>>> rtl/core/btr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap text renderer job queue
// Small FIFO of glyph jobs between the front end and the row generator.
// ----------------------------------------------------------------------------
module btr_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  btr_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output btr_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    btr_pkg::job_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/core/btr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap text renderer row generator
// Walks the rows of each glyph job and emits one addressed row per transfer.
// ----------------------------------------------------------------------------
`include "bitmap_text_renderer_top_macros.svh"

module btr_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  btr_pkg::job_t  q_head,
    output logic           q_pop,
    input  logic [15:0]    row_pitch,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata,   // byte_offset, pixel_x, pixel_y, glyph_bits,
                                      // pixel_count, fore_out, back_out
    output logic           m_tlast    // last
);

    logic [3:0]  row_cnt_reg, row_cnt_next;
    logic        s1_valid_reg;
    logic [11:0] s1_x_reg, s1_y_reg;
    logic [7:0]  s1_bits_reg;
    logic [3:0]  s1_cnt_reg;
    logic [31:0] s1_fg_reg, s1_bg_reg;
    logic        s1_last_reg;

    logic        out_valid_reg;
    logic [27:0] out_off_reg;
    logic [11:0] out_x_reg, out_y_reg;
    logic [7:0]  out_bits_reg;
    logic [3:0]  out_cnt_reg;
    logic [31:0] out_fg_reg, out_bg_reg;
    logic        out_last_reg;

    logic        out_ready, s1_adv, issue, row_end;
    logic [27:0] offset;

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_adv    = !s1_valid_reg || out_ready;
    assign issue     = q_valid && s1_adv;
    assign row_end   = (row_cnt_reg == q_head.rows_m1);
    assign q_pop     = issue && row_end;

    assign row_cnt_next = row_end ? '0 : row_cnt_reg + 4'd1;
    assign offset = (28'(s1_y_reg) * 28'(row_pitch)) + {14'd0, s1_x_reg, 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                row_cnt_reg <= row_cnt_next;
            end
            if (s1_adv)
            begin
                s1_valid_reg <= q_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_x_reg    <= q_head.x;
            s1_y_reg    <= q_head.y + 12'(row_cnt_reg);
            s1_bits_reg <= btr_pkg::glyph_row(q_head.idx, row_cnt_reg);
            s1_cnt_reg  <= q_head.cnt;
            s1_fg_reg   <= q_head.fg;
            s1_bg_reg   <= q_head.bg;
            s1_last_reg <= row_end;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_off_reg  <= offset;
            out_x_reg    <= s1_x_reg;
            out_y_reg    <= s1_y_reg;
            out_bits_reg <= s1_bits_reg;
            out_cnt_reg  <= s1_cnt_reg;
            out_fg_reg   <= s1_fg_reg;
            out_bg_reg   <= s1_bg_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_bg_reg, out_fg_reg, out_cnt_reg, out_bits_reg,
                       out_y_reg, out_x_reg, out_off_reg};

    `BTR_ASSERT_NOW(a_row_in_job, q_valid, row_cnt_reg <= q_head.rows_m1, "row past job end")
    `BTR_ASSERT_NOW(a_row_needs_job, row_cnt_reg != 4'd0, q_valid, "row count without job")
    `BTR_ASSERT_NEXT(a_mid_job, issue && !row_end, row_cnt_reg != 4'd0, "row count lost")
    `BTR_ASSERT_NOW(a_count_range, out_valid_reg, out_cnt_reg != 4'd0 && out_cnt_reg <= 4'd8,
                    "pixel count out of range")

endmodule

>>> rtl/core/bitmap_text_renderer_top.sv
`timescale 1ns / 1ps
// Path: a drawn character's rows pass the job queue, then the s1 and the output registers.
// Throughput: one glyph row per cycle from the row generator unless m_tready stalls it;
//   a character with n visible rows (16 at most) takes n rows, newlines and characters
//   clipped off screen never reach the queue. The job queue lets the front run ahead.
// Reset: cursor and line start clear to 0, screen 640 x 480, pitch 2560, queue empty.
// ----------------------------------------------------------------------------
// Bitmap text renderer
// 8x16 bitmap font renderer: cursor tracking, clipping and per-row addressing.
// ----------------------------------------------------------------------------
module bitmap_text_renderer_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [95:0]    s_tdata,    // origin_x, origin_y, char_code, fore_colour,
                                       // back_colour
    input  logic           s_tuser,    // start_req
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata,    // byte_offset, pixel_x, pixel_y, glyph_bits,
                                       // pixel_count, fore_out, back_out
    output logic           m_tlast,    // last
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    logic [12:0]    screen_width_reg;
    logic [12:0]    screen_height_reg;
    logic [15:0]    row_pitch_reg;

    logic           q_push, q_full, q_pop, q_valid;
    btr_pkg::job_t  q_job, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= 13'd640;
            screen_height_reg <= 13'd480;
            row_pitch_reg     <= 16'd2560;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                btr_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[12:0];
                btr_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[12:0];
                btr_pkg::CFG_ROW_PITCH:     row_pitch_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    btr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_job)
    );

    btr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    btr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .row_pitch (row_pitch_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
